@@ sv/rotate_point_about_center_defines.svh @@
// Assertion macros shared by the checker files of rotate_point_about_center.
// Each macro expands to one labeled concurrent assertion on clk_i / rst_ni.
`ifndef ROTATE_POINT_ABOUT_CENTER_DEFINES_SVH
`define ROTATE_POINT_ABOUT_CENTER_DEFINES_SVH

// same-cycle implication
`define RPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpc assertion failed");

// next-cycle implication
`define RPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpc assertion failed");

`endif

@@ sv/rpc_pkg.sv @@
// Shared types and constants for the point rotation pipeline.
// Used by rpc_prep, rpc_cell, rpc_post and rotate_point_about_center.
`timescale 1ns / 1ps

package rpc_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int MAX_STEPS        = 31;

  // offset in Q.32 (16 guard bits below Q16.16), angle accumulator width
  localparam int VEC_W  = 51;
  localparam int ANG_W  = 34;
  localparam int PROD_W = VEC_W + 15;

  localparam logic signed [31:0]      GAIN_Q31 = 32'sh4DBA76D4;
  localparam logic signed [PROD_W-1:0] PROD_RND = PROD_W'(64'sd16384);
  localparam logic signed [ANG_W-1:0]  Z_BIAS   = ANG_W'(64'sh2000_0000);

  localparam logic [29:0] ATAN_TURNS [MAX_STEPS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
    30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
    30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
    30'h00000001
  };

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic signed [31:0]      cx;
    logic signed [31:0]      cy;
  } rpc_vec_t;

endpackage

@@ sv/rotate_point_about_center.sv @@
// Rotate a Q16.16 point about a center by a binary angle (full turn = 2^32).
// Top level: rpc_prep, a row of CORDIC_STEPS rpc_cell stages, rpc_post and
// an output skid register. Depends on rpc_pkg.
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries point, center and angle;
//   output channel out_valid_o / out_ready_i carries rotated_x/y and the
//   saturated flag. One result per input transaction, in order.
//   From acceptance to out_valid_o the stages are offset, gain multiply,
//   quadrant, one stage per micro-rotation and round/clamp. Throughput: one
//   transaction per cycle while in_ready_o is high; the pipeline of
//   single-rotation cells sets the rate.
//   When the receiver stalls, the result in the last stage moves to a skid
//   register and the pipeline keeps moving for that cycle; in_ready_o drops
//   while the skid register is full and returns when it is drained.
//   in_ready_o is a register output with no path from out_ready_i.
//   Reset (rst_ni low, asynchronous) empties every stage; nothing else needs
//   clearing.
`timescale 1ns / 1ps

module rotate_point_about_center import rpc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic [31:0]        turn_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] rotated_x_o,
  output logic signed [31:0] rotated_y_o,
  output logic               saturated_o
);

  logic                  en;
  logic                  chain_v [CORDIC_STEPS+1];
  rpc_vec_t              chain   [CORDIC_STEPS+1];
  logic                  f_valid, f_sat;
  logic signed [31:0]    f_x, f_y;
  logic                  skid_v_q;
  logic signed [31:0]    skid_x_q, skid_y_q;
  logic                  skid_sat_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  rpc_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .turn_angle_i (turn_angle_i),
    .valid_o      (chain_v[0]),
    .vec_o        (chain[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    rpc_cell #(.STEP(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[g]),
      .vec_i   (chain[g]),
      .valid_o (chain_v[g+1]),
      .vec_o   (chain[g+1])
    );
  end

  rpc_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (chain_v[CORDIC_STEPS]),
    .vec_i       (chain[CORDIC_STEPS]),
    .valid_o     (f_valid),
    .rotated_x_o (f_x),
    .rotated_y_o (f_y),
    .saturated_o (f_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (en && f_valid && !out_ready_i) begin
      skid_v_q <= 1'b1;
    end else if (skid_v_q && out_ready_i) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      skid_x_q   <= f_x;
      skid_y_q   <= f_y;
      skid_sat_q <= f_sat;
    end
  end

  assign out_valid_o = skid_v_q | f_valid;
  assign rotated_x_o = skid_v_q ? skid_x_q : f_x;
  assign rotated_y_o = skid_v_q ? skid_y_q : f_y;
  assign saturated_o = skid_v_q ? skid_sat_q : f_sat;

endmodule

@@ sv/rpc_prep.sv @@
// Front of the pipeline: offset, gain compensation, quadrant rotation.
// Three register stages; depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_prep import rpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic [31:0]        turn_angle_i,
  output logic               valid_o,
  output rpc_vec_t           vec_o
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic                     v1_q, v2_q, v3_q;
  logic signed [32:0]       dx_q, dy_q, dx_d, dy_d;
  logic signed [31:0]       cx1_q, cy1_q, cx2_q, cy2_q;
  logic [31:0]              ang1_q, ang2_q;
  logic signed [PROD_W-1:0] prx_q, pry_q, prx_d, pry_d;
  logic signed [PROD_W-1:0] rx_s, ry_s;
  logic signed [VEC_W-1:0]  x0, y0;
  logic [31:0]              t_ang;
  rpc_vec_t                 vec_d, vec_q;

  assign dx_d = 33'(point_x_i) - 33'(center_x_i);
  assign dy_d = 33'(point_y_i) - 33'(center_y_i);
  assign prx_d = PROD_W'(dx_q) * PROD_W'(GAIN_Q31);
  assign pry_d = PROD_W'(dy_q) * PROD_W'(GAIN_Q31);

  always_comb begin
    rx_s  = prx_q + PROD_RND;
    ry_s  = pry_q + PROD_RND;
    x0    = rx_s[VEC_W+14:15];
    y0    = ry_s[VEC_W+14:15];
    t_ang = ang2_q + 32'h2000_0000;
    vec_d.cx = cx2_q;
    vec_d.cy = cy2_q;
    vec_d.z  = $signed({{(ANG_W-30){1'b0}}, t_ang[29:0]}) - Z_BIAS;
    case (t_ang[31:30])
      QUAD_0: begin
        vec_d.x = x0;
        vec_d.y = y0;
      end
      QUAD_1: begin
        vec_d.x = -y0;
        vec_d.y = x0;
      end
      QUAD_2: begin
        vec_d.x = -x0;
        vec_d.y = -y0;
      end
      QUAD_3: begin
        vec_d.x = y0;
        vec_d.y = -x0;
      end
      default: begin
        vec_d.x = x0;
        vec_d.y = y0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      cx1_q  <= center_x_i;
      cy1_q  <= center_y_i;
      ang1_q <= turn_angle_i;
      prx_q  <= prx_d;
      pry_q  <= pry_d;
      cx2_q  <= cx1_q;
      cy2_q  <= cy1_q;
      ang2_q <= ang1_q;
      vec_q  <= vec_d;
    end
  end

  assign valid_o = v3_q;
  assign vec_o   = vec_q;

endmodule

@@ sv/rpc_cell.sv @@
// One CORDIC micro-rotation cell with its own stage register.
// STEP sets the shift and the arctangent entry; depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_cell import rpc_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  rpc_vec_t vec_i,
  output logic     valid_o,
  output rpc_vec_t vec_o
);

  localparam logic signed [ANG_W-1:0] ATAN_STEP =
    $signed({{(ANG_W-30){1'b0}}, ATAN_TURNS[STEP]});

  logic signed [VEC_W-1:0] xs, ys;
  logic                    valid_q;
  rpc_vec_t                vec_d, vec_q;

  assign xs = $signed(vec_i.x) >>> STEP;
  assign ys = $signed(vec_i.y) >>> STEP;

  always_comb begin
    vec_d = vec_i;
    if (!vec_i.z[ANG_W-1]) begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - ATAN_STEP;
    end else begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + ATAN_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

@@ sv/rpc_post.sv @@
// Back of the pipeline: round off guard bits, add center, clamp to 32 bits.
// One register stage; depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_post import rpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  rpc_vec_t           vec_i,
  output logic               valid_o,
  output logic signed [31:0] rotated_x_o,
  output logic signed [31:0] rotated_y_o,
  output logic               saturated_o
);

  localparam int OW = VEC_W - 16;
  localparam logic signed [VEC_W-1:0] RND = VEC_W'(64'sd32768);
  localparam logic signed [OW:0] S_MAX = (OW+1)'(64'sh7FFF_FFFF);
  localparam logic signed [OW:0] S_MIN = (OW+1)'(-64'sh8000_0000);

  logic signed [VEC_W-1:0] xr, yr;
  logic signed [OW-1:0]    ox, oy;
  logic signed [OW:0]      sx, sy;
  logic signed [31:0]      rx_d, ry_d, rx_q, ry_q;
  logic                    hx, hy, sat_q, valid_q;

  always_comb begin
    xr = vec_i.x + RND;
    yr = vec_i.y + RND;
    ox = xr[VEC_W-1:16];
    oy = yr[VEC_W-1:16];
    sx = (OW+1)'(vec_i.cx) + (OW+1)'(ox);
    sy = (OW+1)'(vec_i.cy) + (OW+1)'(oy);
    hx = (sx > S_MAX) || (sx < S_MIN);
    hy = (sy > S_MAX) || (sy < S_MIN);
    if (sx > S_MAX)      rx_d = 32'sh7FFF_FFFF;
    else if (sx < S_MIN) rx_d = 32'sh8000_0000;
    else                 rx_d = sx[31:0];
    if (sy > S_MAX)      ry_d = 32'sh7FFF_FFFF;
    else if (sy < S_MIN) ry_d = 32'sh8000_0000;
    else                 ry_d = sy[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      sat_q <= hx | hy;
    end
  end

  assign valid_o     = valid_q;
  assign rotated_x_o = rx_q;
  assign rotated_y_o = ry_q;
  assign saturated_o = sat_q;

endmodule

@@ sv/rpc_checker.sv @@
// Port-level checker for rotate_point_about_center, bound to the top level.
// Uses the macros of rotate_point_about_center_defines.svh.
`timescale 1ns / 1ps
`include "rotate_point_about_center_defines.svh"

module rpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] rotated_x_o,
  input logic signed [31:0] rotated_y_o,
  input logic               saturated_o
);

  // input backpressure only while a held result is offered
  `RPC_ASSERT_IMPL(a_stall_shows_result, !in_ready_o, out_valid_o)

  // a clamp flag means a coordinate sits at a range limit
  `RPC_ASSERT_IMPL(a_sat_at_limit, out_valid_o && saturated_o,
    (rotated_x_o == 32'sh7FFF_FFFF) || (rotated_x_o == 32'sh8000_0000) ||
    (rotated_y_o == 32'sh7FFF_FFFF) || (rotated_y_o == 32'sh8000_0000))

  `RPC_ASSERT_NEXT(a_out_valid_holds, out_valid_o && !out_ready_i, out_valid_o)

  `RPC_ASSERT_NEXT(a_out_payload_holds, out_valid_o && !out_ready_i,
    $stable(rotated_x_o) && $stable(rotated_y_o) && $stable(saturated_o))

endmodule

bind rotate_point_about_center rpc_checker u_rpc_checker (.*);

@@ test/rotate_point_about_center_tb.sv @@
// Self-checking testbench for rotate_point_about_center: drives point, center and angle
// transactions with random gaps and stalls, predicts each rotated point in 64-bit
// integer CORDIC arithmetic and compares it. Depends on rpc_pkg and the block's RTL.
`timescale 1ns / 1ps

module rotate_point_about_center_tb;
  import rpc_pkg::*;

  localparam int     STEPS     = CORDIC_STEPS_DEF;
  localparam int     LATENCY   = STEPS + 3;
  localparam longint KGAIN_Q31 = 64'sd1304065748;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint ARCTAN [31] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001
  };

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0]        angle;
  } point_req_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               sat;
  } rotated_t;

  typedef enum int {FULL_RANGE, NEAR_CENTER, NEAR_EDGE} spread_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] point_x_i;
  logic signed [31:0] point_y_i;
  logic signed [31:0] center_x_i;
  logic signed [31:0] center_y_i;
  logic [31:0]        turn_angle_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] rotated_x_o;
  logic signed [31:0] rotated_y_o;
  logic               saturated_o;

  rotated_t expected_rotations [$];
  rotated_t want;
  int       mismatch_count = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_clamped = 0;
  bit       idle_sender = 1'b1;
  bit       idle_receiver = 1'b1;

  rotate_point_about_center #(
    .CORDIC_STEPS(STEPS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .turn_angle_i(turn_angle_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rotated_x_o (rotated_x_o),
    .rotated_y_o (rotated_y_o),
    .saturated_o (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic rotated_t rotate_about_center(point_req_t r);
    longint      x, y, xs, ys, z, tmp, rx, ry;
    logic [31:0] t;
    rotated_t    res;
    x = ((longint'(r.px) - longint'(r.cx)) * KGAIN_Q31 + 64'sd16384) >>> 15;
    y = ((longint'(r.py) - longint'(r.cy)) * KGAIN_Q31 + 64'sd16384) >>> 15;
    t = r.angle + 32'h2000_0000;
    z = longint'(t[29:0]) - 64'sd536870912;
    case (t[31:30])
      2'd1: begin
        tmp = x; x = -y; y = tmp;
      end
      2'd2: begin
        x = -x; y = -y;
      end
      2'd3: begin
        tmp = x; x = y; y = -tmp;
      end
      default: ;
    endcase
    for (int i = 0; i < STEPS && i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ARCTAN[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ARCTAN[i];
      end
    end
    rx = longint'(r.cx) + ((x + 64'sd32768) >>> 16);
    ry = longint'(r.cy) + ((y + 64'sd32768) >>> 16);
    res.sat = 1'b0;
    if (rx > COORD_MAX) begin
      rx = COORD_MAX; res.sat = 1'b1;
    end else if (rx < COORD_MIN) begin
      rx = COORD_MIN; res.sat = 1'b1;
    end
    if (ry > COORD_MAX) begin
      ry = COORD_MAX; res.sat = 1'b1;
    end else if (ry < COORD_MIN) begin
      ry = COORD_MIN; res.sat = 1'b1;
    end
    res.x = rx[31:0];
    res.y = ry[31:0];
    return res;
  endfunction

  function automatic point_req_t random_point(spread_e spread);
    point_req_t  r;
    logic [31:0] ofs_x, ofs_y;
    r.angle = $urandom();
    if ($urandom_range(0, 7) == 0)
      r.angle = ($urandom_range(0, 7) << 29) + $urandom_range(0, 2) - 1;
    case (spread)
      NEAR_CENTER: begin
        r.cx  = $urandom();
        r.cy  = $urandom();
        ofs_x = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
        ofs_y = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
        r.px  = r.cx + ofs_x;
        r.py  = r.cy + ofs_y;
      end
      NEAR_EDGE: begin
        r.cx = $urandom_range(0, 1) ? 32'h7F00_0000 + $urandom_range(0, 32'hFF_FFFF)
                                    : 32'h8000_0000 + $urandom_range(0, 32'hFF_FFFF);
        r.cy = $urandom_range(0, 1) ? 32'h7F00_0000 + $urandom_range(0, 32'hFF_FFFF)
                                    : 32'h8000_0000 + $urandom_range(0, 32'hFF_FFFF);
        r.px = $urandom();
        r.py = $urandom();
      end
      default: begin
        r.cx = $urandom();
        r.cy = $urandom();
        r.px = $urandom();
        r.py = $urandom();
      end
    endcase
    if ($urandom_range(0, 15) == 0) begin
      r.px = r.cx;
      r.py = r.cy;
    end
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_point(input point_req_t r);
    if (idle_sender && $urandom_range(0, 99) < 11) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    point_x_i    = r.px;
    point_y_i    = r.py;
    center_x_i   = r.cx;
    center_y_i   = r.cy;
    turn_angle_i = r.angle;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rotations.push_back(rotate_about_center(r));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_until_drained();
    in_valid_i = 1'b0;
    while (expected_rotations.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_point(point_req_t'{32'sh1234_5678, -32'sh1000, 32'sh1234_5678, -32'sh1000, 32'h4000_0000});
    send_point(point_req_t'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    send_point(point_req_t'{32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0, 32'h0000_0000});
    send_point(point_req_t'{32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0, 32'h4000_0000});
    send_point(point_req_t'{32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0, 32'h8000_0000});
    send_point(point_req_t'{32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0, 32'hC000_0000});
    send_point(point_req_t'{32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0, 32'hFFFF_FFFF});
    send_point(point_req_t'{32'sh0003_0000, 32'sh0002_0000, 32'sh0, 32'sh0, 32'h1FFF_FFFF});
    send_point(point_req_t'{32'sh0003_0000, 32'sh0002_0000, 32'sh0, 32'sh0, 32'h2000_0000});
    send_point(point_req_t'{32'sh0003_0000, 32'sh0002_0000, 32'sh0, 32'sh0, 32'hDFFF_FFFF});
    send_point(point_req_t'{32'sh0003_0000, 32'sh0002_0000, 32'sh0, 32'sh0, 32'hE000_0000});
    // widest offsets
    send_point(point_req_t'{32'h7FFF_FFFF, 32'sh0, 32'h8000_0000, 32'sh0, 32'h0000_0000});
    send_point(point_req_t'{32'h7FFF_FFFF, 32'sh0, 32'h8000_0000, 32'sh0, 32'h8000_0000});
    send_point(point_req_t'{32'h8000_0000, 32'sh0, 32'h7FFF_FFFF, 32'sh0, 32'h4000_0000});
    send_point(point_req_t'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            32'h6000_0000});
    send_point(point_req_t'{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'hA000_0000});
    // clamping on one coordinate
    send_point(point_req_t'{32'sh7000_0000, -32'sh4000_0000, 32'sh7000_0000, 32'sh0,
                            32'h4000_0000});
    send_point(point_req_t'{32'sh4000_0000, -32'sh7000_0000, 32'sh0, -32'sh7000_0000,
                            32'hC000_0000});
    send_point(point_req_t'{-32'sh1, 32'sh0, 32'sh0, 32'sh0, 32'h1234_5678});
    send_point(point_req_t'{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'h5A5A_5A5A});
  endtask

  task automatic test_random(input spread_e spread, input int n);
    repeat (n) send_point(random_point(spread));
  endtask

  task automatic test_back_to_back(input int n);
    idle_sender   = 1'b0;
    idle_receiver = 1'b0;
    repeat (n) send_point(random_point(FULL_RANGE));
    idle_sender   = 1'b1;
    idle_receiver = 1'b1;
  endtask

  task automatic test_drain_pause(input int n);
    repeat (n) send_point(random_point(NEAR_CENTER));
    wait_until_drained();
    repeat (n) send_point(random_point(FULL_RANGE));
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = !(idle_receiver && $urandom_range(0, 99) < 11);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rotations.size() == 0) begin
        $error("result transaction with no pending input: x=%0d y=%0d sat=%0b",
               rotated_x_o, rotated_y_o, saturated_o);
        mismatch_count++;
      end else begin
        want = expected_rotations.pop_front();
        n_checked++;
        if (want.sat) n_clamped++;
        if (rotated_x_o !== want.x) begin
          $error("rotated_x: expected %0d, got %0d", want.x, rotated_x_o);
          mismatch_count++;
        end
        if (rotated_y_o !== want.y) begin
          $error("rotated_y: expected %0d, got %0d", want.y, rotated_y_o);
          mismatch_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    point_x_i    = '0;
    point_y_i    = '0;
    center_x_i   = '0;
    center_y_i   = '0;
    turn_angle_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(FULL_RANGE, 300);
    test_random(NEAR_CENTER, 150);
    test_random(NEAR_EDGE, 150);
    test_back_to_back(200);
    test_drain_pause(50);

    wait_until_drained();
    repeat (LATENCY + 8) @(posedge clk_i);
    $display("Checked %0d of %0d transactions (%0d clamped): corner angles, zero offsets,",
             n_checked, n_sent, n_clamped);
    $display("full-range, near-center and near-edge points, back-to-back and drain pause.");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
